### rtl/core/pact_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page access count table package
// Shared widths, status codes and the transaction structs passed between the
// input register, the table and the result register.
// ----------------------------------------------------------------------------
package pact_pkg;

  // Default table depth.
  localparam int TABLE_ENTRIES_DEF = 64;

  // Fixed field widths of a transaction.
  localparam int PAGE_W  = 32;
  localparam int COUNT_W = 32;
  localparam int RIDX_W  = 6;
  localparam int SLOT_W  = 6;
  localparam int USED_W  = 7;

  // Operation selected by the mode field.
  typedef enum logic {
    MODE_RECORD = 1'b0,
    MODE_READ   = 1'b1
  } mode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_HIT        = 3'd1,
    ST_FULL       = 3'd2,
    ST_READ_VALID = 3'd3,
    ST_READ_EMPTY = 3'd4
  } status_t;

  // Registered input transaction.
  typedef struct packed {
    logic              valid;
    mode_t             mode;
    logic [PAGE_W-1:0] page;
    logic [RIDX_W-1:0] ridx;
  } req_t;

  // Result transaction fields.
  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [PAGE_W-1:0]  page;
    logic [COUNT_W-1:0] count;
    logic [USED_W-1:0]  used;
  } res_t;

endpackage

### rtl/core/pact_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page access count table input register
// Captures each accepted transaction and marks it valid for one cycle.
// ----------------------------------------------------------------------------
module pact_in_stage
  import pact_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              mode,
  input  logic [PAGE_W-1:0] access_page,
  input  logic [RIDX_W-1:0] read_index,
  output req_t              req
);

  // The valid flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= accept;
    end
  end

  // Payload is loaded only when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      req.mode <= mode_t'(mode);
      req.page <= access_page;
      req.ridx <= read_index;
    end
  end

endmodule

### rtl/core/pact_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page access count table storage and match
// Holds the page and count of every slot, matches a page against all filled
// slots in parallel, updates the table and forms the result fields.
// ----------------------------------------------------------------------------
module pact_table
  import pact_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  output res_t res
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W+RIDX_W-1:0] ENTRIES_EXT = (IDX_W + RIDX_W)'(TABLE_ENTRIES);

  logic [PAGE_W-1:0]  slot_page  [TABLE_ENTRIES];
  logic [COUNT_W-1:0] slot_count [TABLE_ENTRIES];
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   used_next;

  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic [COUNT_W-1:0]       hit_count;
  logic                     full;
  logic [IDX_W-1:0]         alloc_idx;
  logic [IDX_W+RIDX_W-1:0]  ridx_ext;
  logic                     rd_in_range;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_valid;
  logic [IDX_W+SLOT_W-1:0]  slot_ext;
  logic [CNT_W+USED_W-1:0]  used_ext;
  logic                     do_hit;
  logic                     do_alloc;

  // Slots fill in order, so a slot holds an entry when its index is below the
  // fill count. Compare the page against every filled slot.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = (CNT_W'(i) < used) && (slot_page[i] == req.page);
    end
  end

  // Lowest matching slot wins.
  always_comb begin
    hit_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign full      = (used == FULL_CNT);
  assign alloc_idx = used[IDX_W-1:0];

  // Saturating increment of the matched count.
  always_comb begin
    if (slot_count[hit_idx] == '1) begin
      hit_count = slot_count[hit_idx];
    end else begin
      hit_count = slot_count[hit_idx] + COUNT_W'(1);
    end
  end

  // Read index decode; an index past the table reads as empty.
  assign ridx_ext    = {{IDX_W{1'b0}}, req.ridx};
  assign rd_in_range = (ridx_ext < ENTRIES_EXT);
  assign rd_idx      = ridx_ext[IDX_W-1:0];
  assign rd_valid    = rd_in_range && (CNT_W'(rd_idx) < used);

  assign do_hit   = req.valid && (req.mode == MODE_RECORD) && hit;
  assign do_alloc = req.valid && (req.mode == MODE_RECORD) && !hit && !full;

  assign used_next = do_alloc ? used + CNT_W'(1) : used;

  // Table update: bump a hit, or allocate the next free slot with count one.
  always_ff @(posedge clk) begin
    if (do_hit) begin
      slot_count[hit_idx] <= hit_count;
    end else if (do_alloc) begin
      slot_page[alloc_idx]  <= req.page;
      slot_count[alloc_idx] <= COUNT_W'(1);
    end
  end

  // Fill count is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  // Result fields.
  always_comb begin
    slot_ext = '0;
    res.page = req.page;
    res.count = '0;
    if (req.mode == MODE_READ) begin
      slot_ext = {{IDX_W{1'b0}}, req.ridx};
      if (rd_valid) begin
        res.status = ST_READ_VALID;
        res.page   = slot_page[rd_idx];
        res.count  = slot_count[rd_idx];
      end else begin
        res.status = ST_READ_EMPTY;
        res.page   = '0;
      end
    end else if (hit) begin
      res.status = ST_HIT;
      slot_ext   = {{SLOT_W{1'b0}}, hit_idx};
      res.count  = hit_count;
    end else if (!full) begin
      res.status = ST_NEW;
      slot_ext   = {{SLOT_W{1'b0}}, alloc_idx};
      res.count  = COUNT_W'(1);
    end else begin
      res.status = ST_FULL;
    end
  end

  assign res.slot = slot_ext[SLOT_W-1:0];
  assign used_ext = {{USED_W{1'b0}}, used_next};
  assign res.used = used_ext[USED_W-1:0];

endmodule

### rtl/core/pact_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page access count table result register
// Registers the result fields and raises the strobe for one cycle.
// ----------------------------------------------------------------------------
module pact_out_stage
  import pact_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  input  res_t res_in,
  output logic done,
  output res_t res_out
);

  // Strobe is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  // Result payload is loaded with each finished transaction.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_out <= res_in;
    end
  end

endmodule

### rtl/core/page_access_count_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page access count table
// Associative table of distinct page addresses with saturating access counts.
// ----------------------------------------------------------------------------
// A transaction is taken whenever start is high; busy is never raised, so one
// transaction can be issued every clock cycle. Each transaction yields exactly
// one result, registered in the input and result registers and shown for one
// cycle with done high; the receiver must take it then, since results cannot
// be held off. A record transaction (mode 0) matches access_page against every
// filled slot through a parallel compare, and the slot update lands before the
// next transaction reaches the table, so back-to-back accesses to one page
// count correctly. Slots fill in order from 0; once all are filled, new pages
// are dropped with status 2. A read transaction (mode 1) returns one slot.
// ----------------------------------------------------------------------------
module page_access_count_table
  import pact_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [PAGE_W-1:0]  access_page,
  input  logic [RIDX_W-1:0]  read_index,
  output logic               done,
  output logic [2:0]         status,
  output logic [SLOT_W-1:0]  entry_slot,
  output logic [PAGE_W-1:0]  entry_page,
  output logic [COUNT_W-1:0] entry_count,
  output logic [USED_W-1:0]  entries_used
);

  req_t req;
  res_t res_next;
  res_t res;
  logic accept;

  // The table never stalls, so busy is tied low.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register.
  pact_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .mode        (mode),
    .access_page (access_page),
    .read_index  (read_index),
    .req         (req)
  );

  // Match, update and result forming.
  pact_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res_next)
  );

  // Result register.
  pact_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_valid (req.valid),
    .res_in    (res_next),
    .done      (done),
    .res_out   (res)
  );

  assign status       = res.status;
  assign entry_slot   = res.slot;
  assign entry_page   = res.page;
  assign entry_count  = res.count;
  assign entries_used = res.used;

endmodule

### tb/tb_page_access_count_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page access count table testbench
// Runs a short table of directed transactions and then a few hundred random
// ones through the block. A local copy of the table predicts every result.
// Directed rows with obvious outcomes carry their results typed in. Each done
// strobe is checked field by field against the oldest pending prediction.
// The random part fills the table and then keeps hitting and dropping pages.
// ----------------------------------------------------------------------------
module tb_page_access_count_table;
  import pact_pkg::*;

  localparam int ENTRIES     = TABLE_ENTRIES_DEF;
  localparam int RANDOM_OPS  = 400;
  localparam int IDLE_LIMIT  = 200;
  localparam int DRAIN_TICKS = 10;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    mode_t             mode;
    logic [PAGE_W-1:0] page;
    logic [RIDX_W-1:0] ridx;
    bit                typed;
    res_t              want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               mode = MODE_RECORD;
  logic [PAGE_W-1:0]  access_page = '0;
  logic [RIDX_W-1:0]  read_index = '0;
  logic               done;
  logic [2:0]         status;
  logic [SLOT_W-1:0]  entry_slot;
  logic [PAGE_W-1:0]  entry_page;
  logic [COUNT_W-1:0] entry_count;
  logic [USED_W-1:0]  entries_used;

  // Local copy of the table.
  logic               tbl_valid [ENTRIES];
  logic [PAGE_W-1:0]  tbl_page  [ENTRIES];
  logic [COUNT_W-1:0] tbl_hits  [ENTRIES];
  logic [USED_W-1:0]  tbl_used;

  res_t              expected_entries [$];
  logic [PAGE_W-1:0] recorded_pages [$];
  dir_row_t          dir_rows [$];
  int                err_count = 0;
  int                idle_cycles = 0;

  page_access_count_table i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .access_page  (access_page),
    .read_index   (read_index),
    .done         (done),
    .status       (status),
    .entry_slot   (entry_slot),
    .entry_page   (entry_page),
    .entry_count  (entry_count),
    .entries_used (entries_used)
  );

  always #4 clk = ~clk;

  // Apply one transaction to the local table and return its result.
  function automatic res_t table_access(mode_t op, logic [PAGE_W-1:0] pg,
                                        logic [RIDX_W-1:0] ridx);
    res_t r;
    int   hit_slot;
    r = '0;
    hit_slot = -1;
    if (op == MODE_READ) begin
      r.slot = ridx;
      if (ridx < ENTRIES && tbl_valid[ridx]) begin
        r.status = ST_READ_VALID;
        r.page   = tbl_page[ridx];
        r.count  = tbl_hits[ridx];
      end else begin
        r.status = ST_READ_EMPTY;
      end
      r.used = tbl_used;
      return r;
    end
    // Lowest matching slot wins, although slots are distinct anyway.
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_slot < 0 && tbl_valid[i] && tbl_page[i] == pg) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      if (tbl_hits[hit_slot] != '1) tbl_hits[hit_slot] = tbl_hits[hit_slot] + 1;
      r.status = ST_HIT;
      r.slot   = hit_slot[SLOT_W-1:0];
      r.page   = pg;
      r.count  = tbl_hits[hit_slot];
    end else if (tbl_used < ENTRIES) begin
      tbl_valid[tbl_used] = 1'b1;
      tbl_page[tbl_used]  = pg;
      tbl_hits[tbl_used]  = 1;
      recorded_pages = {recorded_pages, pg};
      r.status = ST_NEW;
      r.slot   = tbl_used[SLOT_W-1:0];
      r.page   = pg;
      r.count  = 1;
      tbl_used = tbl_used + 1;
    end else begin
      // Table full: the page is dropped and nothing changes.
      r.status = ST_FULL;
      r.page   = pg;
    end
    r.used = tbl_used;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("Mismatch in %s at %0t ns: got 0x%0h, expected 0x%0h",
             field, $time, got, want);
    err_count++;
  endtask

  task automatic add_row(mode_t op, logic [PAGE_W-1:0] pg, logic [RIDX_W-1:0] ridx,
                         bit typed, status_t st, logic [SLOT_W-1:0] slot,
                         logic [PAGE_W-1:0] rpage, logic [COUNT_W-1:0] cnt,
                         logic [USED_W-1:0] used);
    dir_row_t row;
    row.mode  = op;
    row.page  = pg;
    row.ridx  = ridx;
    row.typed = typed;
    row.want  = '{status: st, slot: slot, page: rpage, count: cnt, used: used};
    dir_rows = {dir_rows, row};
  endtask

  // Drive one transaction, wait for it to be taken, then idle for the requested gap.
  // A gap of zero keeps start high so the next transaction follows directly.
  task automatic issue(mode_t op, logic [PAGE_W-1:0] pg, logic [RIDX_W-1:0] ridx,
                       bit typed, res_t want, int gap);
    res_t predicted;
    start       <= 1'b1;
    mode        <= op;
    access_page <= pg;
    read_index  <= ridx;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = table_access(op, pg, ridx);
    expected_entries = {expected_entries, (typed ? want : predicted)};
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Check every done strobe against the oldest pending prediction.
  always @(posedge clk) begin
    res_t want;
    if (!rst && done === 1'b1) begin
      if (expected_entries.size() == 0) begin
        $display("Unexpected result at %0t ns: status %0d slot %0d", $time, status,
                 entry_slot);
        err_count++;
      end else begin
        want = expected_entries.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (entry_slot !== want.slot) report_mismatch("entry_slot", entry_slot, want.slot);
        if (entry_page !== want.page) report_mismatch("entry_page", entry_page, want.page);
        if (entry_count !== want.count)
          report_mismatch("entry_count", entry_count, want.count);
        if (entries_used !== want.used)
          report_mismatch("entries_used", entries_used, want.used);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit                no_gaps;
    int                gap;
    int                hit_pct;
    mode_t             op;
    logic [PAGE_W-1:0] pg;
    logic [RIDX_W-1:0] ridx;

    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_page[i]  = '0;
      tbl_hits[i]  = '0;
    end
    tbl_used = '0;

    // Directed table, starting from the empty table after reset.
    add_row(MODE_READ,   32'h0000_0000, 6'd0,  1, ST_READ_EMPTY, 6'd0,  32'h0, 32'd0, 7'd0);
    add_row(MODE_READ,   32'hFFFF_FFFF, 6'd63, 1, ST_READ_EMPTY, 6'd63, 32'h0, 32'd0, 7'd0);
    add_row(MODE_RECORD, 32'h0000_0000, 6'd63, 1, ST_NEW, 6'd0, 32'h0000_0000, 32'd1, 7'd1);
    add_row(MODE_RECORD, 32'hFFFF_FFFF, 6'd0,  1, ST_NEW, 6'd1, 32'hFFFF_FFFF, 32'd1, 7'd2);
    add_row(MODE_RECORD, 32'h0000_0000, 6'd0,  1, ST_HIT, 6'd0, 32'h0000_0000, 32'd2, 7'd2);
    add_row(MODE_RECORD, 32'h0000_0000, 6'd0,  1, ST_HIT, 6'd0, 32'h0000_0000, 32'd3, 7'd2);
    add_row(MODE_READ,   32'h0000_0000, 6'd0,  1, ST_READ_VALID, 6'd0, 32'h0, 32'd3, 7'd2);
    add_row(MODE_READ,   32'h0000_0000, 6'd1,  1, ST_READ_VALID, 6'd1, 32'hFFFF_FFFF, 32'd1,
            7'd2);
    add_row(MODE_READ,   32'h0000_0000, 6'd2,  1, ST_READ_EMPTY, 6'd2, 32'h0, 32'd0, 7'd2);
    add_row(MODE_RECORD, 32'hA5A5_A5A5, 6'd0,  0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_RECORD, 32'h5A5A_5A5A, 6'd0,  0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_RECORD, 32'hFFFF_FFFF, 6'd0,  0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_RECORD, 32'h8000_0000, 6'd0,  0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_RECORD, 32'h0000_0001, 6'd0,  0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_READ,   32'hDEAD_BEEF, 6'd3,  0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_RECORD, 32'hA5A5_A5A5, 6'd63, 0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_RECORD, 32'h0000_0001, 6'd42, 0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_READ,   32'h0000_0000, 6'd42, 0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_READ,   32'h0000_0000, 6'd21, 0, ST_NEW, '0, '0, '0, '0);
    add_row(MODE_READ,   32'h0000_0000, 6'd5,  0, ST_NEW, '0, '0, '0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      gap = (i < 8) ? 0 : $urandom_range(0, 15);
      issue(dir_rows[i].mode, dir_rows[i].page, dir_rows[i].ridx, dir_rows[i].typed,
            dir_rows[i].want, gap);
    end

    // Random part: a mix of hits on known pages, new pages and reads. Late in
    // the run new pages are favored until the table is full, so that drops
    // and reads of a full table are exercised as well.
    no_gaps = 1'b0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) no_gaps = $urandom_range(0, 1);
      gap     = no_gaps ? 0 : $urandom_range(0, 15);
      hit_pct = (n >= 200 && tbl_used < ENTRIES) ? 15 : 50;
      ridx    = $urandom_range(0, 63);
      if ($urandom_range(0, 99) < 30) begin
        op = MODE_READ;
        pg = $urandom();
      end else begin
        op = MODE_RECORD;
        if (recorded_pages.size() > 0 && $urandom_range(0, 99) < hit_pct)
          pg = recorded_pages[$urandom_range(0, recorded_pages.size() - 1)];
        else
          pg = $urandom();
      end
      issue(op, pg, ridx, 1'b0, '0, gap);
    end
    start <= 1'b0;

    // Wait for the outstanding results, then let the pipeline settle.
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
